// ===== rtl/cbn_pkg.sv =====
// shared types, constants and coefficient lookup for the complex biquad notch
// no dependencies
package cbn_pkg;

  localparam int SECTIONS_DEF    = 3;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SECTIONS_MAX    = 8;
  localparam int IDX_MAX_W       = $clog2(2 * SECTIONS_MAX);

  localparam int COEF_BITS = 16;
  localparam int COEF_FRAC = 14;
  localparam int NUM_TAPS  = 5;

  localparam logic signed [COEF_BITS-1:0] COEF_B0 = 16'sd16363;
  localparam logic signed [COEF_BITS-1:0] COEF_B1 = -16'sd32717;
  localparam logic signed [COEF_BITS-1:0] COEF_B2 = 16'sd16363;
  localparam logic signed [COEF_BITS-1:0] COEF_A1 = 16'sd32717;
  localparam logic signed [COEF_BITS-1:0] COEF_A2 = -16'sd16341;

  typedef enum logic [2:0] {
    TAP_X0,
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2
  } tap_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    tap_t                 tap;
    logic                 acc_init;
    logic                 acc_add;
    logic                 finish;
    logic                 out_load;
    logic [IDX_MAX_W-1:0] idx;
  } cbn_cmd_t;

  function automatic logic signed [COEF_BITS-1:0] coef_of(input tap_t tap);
    logic signed [COEF_BITS-1:0] c;
    case (tap)
      TAP_X0:  c = COEF_B0;
      TAP_X1:  c = COEF_B1;
      TAP_X2:  c = COEF_B2;
      TAP_Y1:  c = COEF_A1;
      TAP_Y2:  c = COEF_A2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cbn_ifs.sv =====
// handshake channels of the complex biquad notch: sample in, result out, config
// no dependencies
interface cbn_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_real;
  logic signed [W-1:0] in_imag;
  modport source (output valid, output in_real, output in_imag, input ready);
  modport sink   (input valid, input in_real, input in_imag, output ready);
endinterface

interface cbn_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_real;
  logic signed [W-1:0] out_imag;
  modport source (output valid, output out_real, output out_imag, input ready);
  modport sink   (input valid, input out_real, input out_imag, output ready);
endinterface

interface cbn_cfg_if;
  logic valid;
  logic ready;
  logic notch_enable;
  modport source (output valid, output notch_enable, input ready);
  modport sink   (input valid, input notch_enable, output ready);
endinterface

// ===== rtl/cbn_ctrl.sv =====
// sequencer for the notch: walks taps, sections and channels, owns handshakes
// depends on cbn_pkg
module cbn_ctrl #(
  parameter int SECTIONS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_enable,
  output cbn_pkg::cbn_cmd_t cmd
);
  import cbn_pkg::*;

  localparam int NUM_IDX = 2 * SECTIONS;
  localparam int IDX_W   = (NUM_IDX > 1) ? $clog2(NUM_IDX) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FIN,
    S_OUT
  } state_t;

  state_t           state;
  logic [2:0]       tap_cnt;
  logic [IDX_W-1:0] idx;
  logic             notch_en;
  logic             last_idx;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign last_idx  = (idx == IDX_W'(NUM_IDX - 1));

  always_comb begin
    cmd          = '0;
    cmd.tap      = TAP_X0;
    cmd.idx      = IDX_MAX_W'(idx);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul_en   = (state == S_MAC) && (tap_cnt != 3'(NUM_TAPS));
    if (cmd.mul_en) begin
      cmd.tap = tap_t'(tap_cnt);
    end
    cmd.acc_init = (state == S_MAC) && (tap_cnt == 3'd0);
    cmd.acc_add  = (state == S_MAC) && (tap_cnt != 3'd0);
    cmd.finish   = (state == S_FIN);
    cmd.out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_cnt   <= '0;
      idx       <= '0;
      notch_en  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        notch_en <= cfg_enable;
      end
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          tap_cnt <= '0;
          idx     <= '0;
          if (in_valid) begin
            state <= notch_en ? S_MAC : S_OUT;
          end
        end
        S_MAC: begin
          if (tap_cnt == 3'(NUM_TAPS)) begin
            state <= S_FIN;
          end else begin
            tap_cnt <= tap_cnt + 3'd1;
          end
        end
        S_FIN: begin
          tap_cnt <= '0;
          if (last_idx) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_MAC;
          end
        end
        S_OUT: begin
          // result register must be free before the beat moves in
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cbn_dp.sv =====
// datapath of the notch: history registers, shared multiplier and accumulator
// depends on cbn_pkg
module cbn_dp #(
  parameter int SECTIONS    = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbn_pkg::cbn_cmd_t             cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_real,
  input  logic signed [SAMPLE_BITS-1:0] in_imag,
  output logic signed [SAMPLE_BITS-1:0] out_real,
  output logic signed [SAMPLE_BITS-1:0] out_imag
);
  import cbn_pkg::*;

  localparam int NUM_IDX = 2 * SECTIONS;
  localparam int IDX_W   = (NUM_IDX > 1) ? $clog2(NUM_IDX) : 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W   = PROD_W + 3;
  localparam int Q_W     = ACC_W - COEF_FRAC;

  localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [Q_W-1:0]   SAT_HI = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0]   SAT_LO = -SAT_HI - Q_W'(1);

  logic signed [SAMPLE_BITS-1:0] xh1 [NUM_IDX];
  logic signed [SAMPLE_BITS-1:0] xh2 [NUM_IDX];
  logic signed [SAMPLE_BITS-1:0] yh1 [NUM_IDX];
  logic signed [SAMPLE_BITS-1:0] yh2 [NUM_IDX];
  logic signed [SAMPLE_BITS-1:0] cur [2];

  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [Q_W-1:0]         q;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic [IDX_W-1:0]              idx;
  logic                          chan;

  assign idx  = cmd.idx[IDX_W-1:0];
  assign chan = cmd.idx[0];
  assign coef = coef_of(cmd.tap);

  always_comb begin
    case (cmd.tap)
      TAP_X0:  operand = cur[chan];
      TAP_X1:  operand = xh1[idx];
      TAP_X2:  operand = xh2[idx];
      TAP_Y1:  operand = yh1[idx];
      TAP_Y2:  operand = yh2[idx];
      default: operand = '0;
    endcase
  end

  // rounding offset is preloaded, so only the shift and clamp remain here
  always_comb begin
    q = Q_W'(acc >>> COEF_FRAC);
    if (q > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(coef) * PROD_W'(operand);
    end
    if (cmd.acc_init) begin
      acc <= ROUND_INIT;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.load) begin
      cur[0] <= in_real;
      cur[1] <= in_imag;
    end else if (cmd.finish) begin
      cur[chan] <= y_sat;
    end
    if (cmd.out_load) begin
      out_real <= cur[0];
      out_imag <= cur[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_IDX; i++) begin
        xh1[i] <= '0;
        xh2[i] <= '0;
        yh1[i] <= '0;
        yh2[i] <= '0;
      end
    end else if (cmd.finish) begin
      xh2[idx] <= xh1[idx];
      xh1[idx] <= cur[chan];
      yh2[idx] <= yh1[idx];
      yh1[idx] <= y_sat;
    end
  end

endmodule

// ===== rtl/cascaded_biquad_notch_complex.sv =====
// top level of the complex cascaded biquad notch filter
// depends on cbn_pkg, cbn_ifs, cbn_ctrl and cbn_dp
//
//   port    | dir  | beat carries
//   --------+------+------------------------------------
//   sample  | in   | in_real, in_imag (Q1.15)
//   result  | out  | out_real, out_imag (Q1.15, saturated)
//   cfg     | in   | notch_enable
//
// enabled: each section and channel runs on the one multiplier (5 taps,
// last add, round and update), between the accept and the output step;
// bypassed: only the accept and the output step.
// reset clears history and enable at once.
// a new sample is taken while the previous result still waits in the output
// register; the sequencer only stalls when it must load a still-full register.
module cascaded_biquad_notch_complex #(
  parameter int SECTIONS    = cbn_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS = cbn_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cbn_in_if.sink    sample,
  cbn_out_if.source result,
  cbn_cfg_if.sink   cfg
);
  import cbn_pkg::*;

  cbn_cmd_t cmd;

  cbn_ctrl #(
    .SECTIONS (SECTIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_enable (cfg.notch_enable),
    .cmd        (cmd)
  );

  cbn_dp #(
    .SECTIONS    (SECTIONS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_real  (sample.in_real),
    .in_imag  (sample.in_imag),
    .out_real (result.out_real),
    .out_imag (result.out_imag)
  );

endmodule
